// ===== rtl/gww_pkg.sv =====
// Shared types and constants for the greedy word wrap block.
// No dependencies; imported by the modules below it.
package gww_pkg;

	localparam int ROW_W = 7;
	localparam int COL_W = 7;

	localparam logic [7:0] SPACE_CHAR = 8'd32;
	localparam logic [7:0] DOT_CHAR   = 8'd46;
	localparam logic [7:0] NUL_CHAR   = 8'd0;

	localparam logic [1:0] MODE_TEXT = 2'd0;
	localparam logic [1:0] MODE_EOL  = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	localparam logic KIND_LINE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [1:0] REG_ROW_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROW_LIMIT   = 2'd1;

	// row store access, one per cycle: write or read, never both
	typedef struct packed {
		logic             we;
		logic             re;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [7:0]       wdata;
	} store_cmd_t;

	typedef struct packed {
		logic       we;
		logic       re;
		logic [7:0] waddr;
		logic [7:0] raddr;
		logic [7:0] wdata;
	} wbuf_cmd_t;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [6:0] rows;
		logic [7:0] data;
	} res_t;

endpackage

// ===== rtl/gww_ifs.sv =====
// Valid/ready channel interfaces of the greedy word wrap block.
// Depends on nothing; used by gww_ctrl and greedy_word_wrap.
interface gww_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] text_byte;
	logic [5:0] read_row;
	logic [5:0] read_column;

	modport source (output valid, mode, text_byte, read_row, read_column, input ready);
	modport sink (input valid, mode, text_byte, read_row, read_column, output ready);
endinterface

interface gww_res_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [6:0] rows_used;
	logic [7:0] read_data;

	modport source (output valid, result_kind, rows_used, read_data, input ready);
	modport sink (input valid, result_kind, rows_used, read_data, output ready);
endinterface

interface gww_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [6:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/greedy_word_wrap.sv =====
// Greedy word wrap top level: sequencer, row store, word buffer, result register.
// A text byte that ends no word is written straight into the word buffer; placing a word
// reads and writes its bytes one at a time, and also trims trailing spaces, breaks rows and
// writes an ellipsis where needed; a read request passes through S_EMIT and the result register.
// The one-port row store walk takes one request at a time: a new item is accepted only when idle.
// Reset clears all control state; the row store has no clearing pass.
module greedy_word_wrap
	import gww_pkg::*;
#(
	parameter int ROW_STRIDE = 64,
	parameter int MAX_ROWS   = 64,
	parameter int WORD_CAP   = 254
) (
	input  logic       clk,
	input  logic       arst_n,
	gww_item_if.sink   item,
	gww_res_if.source  result,
	gww_cfg_if.sink    cfg
);

	store_cmd_t st_cmd;
	wbuf_cmd_t  wb_cmd;
	logic [7:0] st_rdata;
	logic [7:0] wb_rdata;
	res_t       res;
	logic       take;

	// result register: parts the sequencer from the consumer
	logic       res_valid_q;
	logic       res_kind_q;
	logic [6:0] res_rows_q;
	logic [7:0] res_data_q;

	// the slot is free when empty or being drained this cycle
	assign take = !res_valid_q || result.ready;

	gww_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.WORD_CAP (WORD_CAP)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg      (cfg),
		.st_cmd   (st_cmd),
		.st_rdata (st_rdata),
		.wb_cmd   (wb_cmd),
		.wb_rdata (wb_rdata),
		.res      (res),
		.take     (take)
	);

	// rows live at row * 2^ceil(log2(ROW_STRIDE)); out-of-range positions read zero
	gww_store #(
		.ROW_STRIDE (ROW_STRIDE),
		.MAX_ROWS   (MAX_ROWS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (st_cmd),
		.rdata  (st_rdata)
	);

	gww_wbuf #(
		.WORD_CAP (WORD_CAP)
	) u_wbuf (
		.clk   (clk),
		.cmd   (wb_cmd),
		.rdata (wb_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.valid) begin
			res_kind_q <= res.kind;
			res_rows_q <= res.rows;
			res_data_q <= res.data;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.result_kind = res_kind_q;
	assign result.rows_used   = res_rows_q;
	assign result.read_data   = res_data_q;

endmodule

// ===== rtl/gww_store.sv =====
// Row store: synchronous memory of zero-terminated rows, registered read.
// Depends on gww_pkg; instantiated by greedy_word_wrap.
module gww_store
	import gww_pkg::*;
#(
	parameter int ROW_STRIDE = 64,
	parameter int MAX_ROWS   = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  store_cmd_t cmd,
	output logic [7:0] rdata
);

	localparam int CA     = $clog2(ROW_STRIDE);
	localparam int RA     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AW     = RA + CA;
	localparam int DEPTH  = MAX_ROWS * (2 ** CA);
	localparam logic [10:0] ROWS_W   = 11'(MAX_ROWS);
	localparam logic [8:0]  STRIDE_W = 9'(ROW_STRIDE);

	logic [7:0]    store_mem_q [DEPTH];
	logic [7:0]    rd_q;
	logic          rd_ok_q;
	logic [AW-1:0] addr;
	logic          in_range;

	assign addr     = {RA'(cmd.row), CA'(cmd.col)};
	// positions outside the store drop writes and read as zero
	assign in_range = ({4'b0, cmd.row} < ROWS_W) && ({2'b0, cmd.col} < STRIDE_W);

	always_ff @(posedge clk) begin
		if (cmd.we && in_range) begin
			store_mem_q[addr] <= cmd.wdata;
		end
		if (cmd.re && in_range) begin
			rd_q <= store_mem_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
		end else if (cmd.re) begin
			rd_ok_q <= in_range;
		end
	end

	assign rdata = rd_ok_q ? rd_q : NUL_CHAR;

endmodule

// ===== rtl/gww_wbuf.sv =====
// Word buffer: bytes of the word being collected, registered read.
// Depends on gww_pkg; instantiated by greedy_word_wrap.
module gww_wbuf
	import gww_pkg::*;
#(
	parameter int WORD_CAP = 254
) (
	input  logic       clk,
	input  wbuf_cmd_t  cmd,
	output logic [7:0] rdata
);

	localparam int WA = (WORD_CAP > 1) ? $clog2(WORD_CAP) : 1;

	logic [7:0] wbuf_mem_q [WORD_CAP];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			wbuf_mem_q[cmd.waddr[WA-1:0]] <= cmd.wdata;
		end
		if (cmd.re) begin
			rd_q <= wbuf_mem_q[cmd.raddr[WA-1:0]];
		end
	end

	assign rdata = rd_q;

endmodule

// ===== rtl/gww_ctrl.sv =====
// Wrap sequencer: word collection, placement, trimming, ellipsis, results.
// Depends on gww_pkg and gww_ifs; drives gww_store and gww_wbuf.
module gww_ctrl
	import gww_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int WORD_CAP = 254
) (
	input  logic        clk,
	input  logic        arst_n,
	gww_item_if.sink    item,
	gww_cfg_if.sink     cfg,
	output store_cmd_t  st_cmd,
	input  logic [7:0]  st_rdata,
	output wbuf_cmd_t   wb_cmd,
	input  logic [7:0]  wb_rdata,
	output res_t        res,
	input  logic        take
);

	localparam logic [10:0] ROWS_W = 11'(MAX_ROWS);
	localparam logic [7:0]  CAP    = 8'(WORD_CAP);

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_PW      = 10'b00_0000_0010,
		S_CP_RD   = 10'b00_0000_0100,
		S_CP_WR   = 10'b00_0000_1000,
		S_TRIM_RD = 10'b00_0001_0000,
		S_TRIM_CK = 10'b00_0010_0000,
		S_TERM    = 10'b00_0100_0000,
		S_ELL     = 10'b00_1000_0000,
		S_POST    = 10'b01_0000_0000,
		S_EMIT    = 10'b10_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		OP_TEXT  = 2'd0,
		OP_SPACE = 2'd1,
		OP_EOL   = 2'd2
	} op_t;

	state_t           state_q, state_d;
	op_t              op_q, op_d;
	logic [7:0]       wl_q, wl_d;
	logic [7:0]       idx_q, idx_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic             ovf_q, ovf_d;
	logic [1:0]       dots_q, dots_d;
	logic             kind_q, kind_d;
	logic [6:0]       count_q, count_d;
	logic             close_q, close_d;
	logic [5:0]       cols_q;
	logic [6:0]       lim_q;

	logic [6:0]       eff_lim;
	logic             enabled;
	logic             brk;
	logic [6:0]       clip_col;
	logic [7:0]       row_inc;
	logic [7:0]       wl_inc;
	logic             row_full;

	assign eff_lim  = ({4'b0, lim_q} > ROWS_W) ? ROWS_W[6:0] : lim_q;
	assign enabled  = (cols_q != 6'd0) && (eff_lim != 7'd0);
	assign row_inc  = {1'b0, row_q} + 8'd1;
	assign wl_inc   = wl_q + 8'd1;
	assign row_full = row_inc >= {1'b0, eff_lim};
	// break before a byte: column used up, or a fitting word that does not fit here
	assign brk = (col_q >= {1'b0, cols_q}) ||
		((idx_q == 8'd0) && (wl_q <= {2'b0, cols_q}) &&
		(({2'b0, col_q} + {1'b0, wl_q}) > {3'b0, cols_q}));
	assign clip_col = (col_q > ({1'b0, cols_q} - 7'd3)) ? ({1'b0, cols_q} - 7'd3) : col_q;

	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;

	assign res.valid = (state_q == S_EMIT);
	assign res.kind  = kind_q;
	assign res.rows  = (kind_q == KIND_LINE) ? count_q : 7'd0;
	assign res.data  = (kind_q == KIND_READ) ? st_rdata : NUL_CHAR;

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		wl_d    = wl_q;
		idx_d   = idx_q;
		col_d   = col_q;
		row_d   = row_q;
		ovf_d   = ovf_q;
		dots_d  = dots_q;
		kind_d  = kind_q;
		count_d = count_q;
		close_d = close_q;
		st_cmd  = '0;
		wb_cmd  = '0;
		case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					case (item.mode)
						MODE_TEXT: begin
							if (enabled && !ovf_q && (item.text_byte != NUL_CHAR)) begin
								if (item.text_byte == SPACE_CHAR) begin
									op_d    = OP_SPACE;
									state_d = S_PW;
								end else begin
									wb_cmd.we    = 1'b1;
									wb_cmd.waddr = wl_q;
									wb_cmd.wdata = item.text_byte;
									wl_d         = wl_inc;
									if (wl_inc >= CAP) begin
										op_d    = OP_TEXT;
										state_d = S_PW;
									end
								end
							end
						end
						MODE_EOL: begin
							kind_d = KIND_LINE;
							if (enabled) begin
								op_d    = OP_EOL;
								state_d = S_PW;
							end else begin
								count_d = 7'd0;
								state_d = S_EMIT;
							end
						end
						MODE_READ: begin
							st_cmd.re  = 1'b1;
							st_cmd.row = {1'b0, item.read_row};
							st_cmd.col = {1'b0, item.read_column};
							kind_d     = KIND_READ;
							state_d    = S_EMIT;
						end
						default: ;
					endcase
				end
			end
			S_PW: begin
				idx_d   = 8'd0;
				state_d = ((wl_q == 8'd0) || ovf_q) ? S_POST : S_CP_RD;
			end
			S_CP_RD: begin
				if (brk) begin
					close_d = 1'b0;
					state_d = S_TRIM_RD;
				end else begin
					wb_cmd.re    = 1'b1;
					wb_cmd.raddr = idx_q;
					state_d      = S_CP_WR;
				end
			end
			S_CP_WR: begin
				st_cmd.we    = 1'b1;
				st_cmd.row   = row_q;
				st_cmd.col   = col_q;
				st_cmd.wdata = wb_rdata;
				col_d        = col_q + 7'd1;
				idx_d        = idx_q + 8'd1;
				state_d      = ((idx_q + 8'd1) == wl_q) ? S_POST : S_CP_RD;
			end
			S_TRIM_RD: begin
				if (col_q == 7'd0) begin
					state_d = S_TERM;
				end else begin
					st_cmd.re  = 1'b1;
					st_cmd.row = row_q;
					st_cmd.col = col_q - 7'd1;
					state_d    = S_TRIM_CK;
				end
			end
			S_TRIM_CK: begin
				if (st_rdata == SPACE_CHAR) begin
					col_d   = col_q - 7'd1;
					state_d = S_TRIM_RD;
				end else begin
					state_d = S_TERM;
				end
			end
			S_TERM: begin
				st_cmd.we    = 1'b1;
				st_cmd.row   = row_q;
				st_cmd.col   = col_q;
				st_cmd.wdata = NUL_CHAR;
				if (close_q) begin
					count_d = row_inc[6:0];
					state_d = S_EMIT;
				end else if (row_full) begin
					if (cols_q >= 6'd3) begin
						col_d  = clip_col;
						dots_d = 2'd3;
					end else begin
						dots_d = 2'd0;
					end
					state_d = S_ELL;
				end else begin
					row_d   = row_inc[ROW_W-1:0];
					col_d   = 7'd0;
					state_d = S_CP_RD;
				end
			end
			S_ELL: begin
				st_cmd.we  = 1'b1;
				st_cmd.row = row_q;
				st_cmd.col = col_q;
				if (dots_q != 2'd0) begin
					st_cmd.wdata = DOT_CHAR;
					col_d        = col_q + 7'd1;
					dots_d       = dots_q - 2'd1;
				end else begin
					st_cmd.wdata = NUL_CHAR;
					ovf_d        = 1'b1;
					state_d      = S_POST;
				end
			end
			S_POST: begin
				wl_d = 8'd0;
				case (op_q)
					OP_SPACE: begin
						// inner space kept only while it fits
						if (!ovf_q && (col_q != 7'd0) && (col_q < {1'b0, cols_q})) begin
							st_cmd.we    = 1'b1;
							st_cmd.row   = row_q;
							st_cmd.col   = col_q;
							st_cmd.wdata = SPACE_CHAR;
							col_d        = col_q + 7'd1;
						end
						state_d = S_IDLE;
					end
					OP_EOL: begin
						if (ovf_q) begin
							count_d = eff_lim;
							state_d = S_EMIT;
						end else begin
							close_d = 1'b1;
							state_d = S_TRIM_RD;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_EMIT: begin
				if (take) begin
					if (kind_q == KIND_LINE) begin
						wl_d  = 8'd0;
						col_d = 7'd0;
						row_d = '0;
						ovf_d = 1'b0;
					end
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_TEXT;
			wl_q    <= 8'd0;
			idx_q   <= 8'd0;
			col_q   <= 7'd0;
			row_q   <= '0;
			ovf_q   <= 1'b0;
			dots_q  <= 2'd0;
			kind_q  <= KIND_LINE;
			count_q <= 7'd0;
			close_q <= 1'b0;
			cols_q  <= 6'd40;
			lim_q   <= 7'd64;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			wl_q    <= wl_d;
			idx_q   <= idx_d;
			col_q   <= col_d;
			row_q   <= row_d;
			ovf_q   <= ovf_d;
			dots_q  <= dots_d;
			kind_q  <= kind_d;
			count_q <= count_d;
			close_q <= close_d;
			if (cfg.valid) begin
				case (cfg.index)
					REG_ROW_COLUMNS: cols_q <= cfg.data[5:0];
					REG_ROW_LIMIT:   lim_q  <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	// single-port use of the row store: the sequencer never reads and writes at once
	a_store_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_cmd.we && st_cmd.re))
		else $error("row store read and write in one cycle");

	a_wbuf_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wb_cmd.we |-> (wb_cmd.waddr < CAP))
		else $error("word buffer write beyond capacity");

	a_ovf_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && ovf_q) |-> (wl_q == 8'd0))
		else $error("word pending after overflow");

	a_read_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && item.valid && (item.mode == MODE_READ)) |=> (state_q == S_EMIT))
		else $error("read request did not reach result stage");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !take) |=> (res.valid && $stable(res.data) && $stable(res.rows)))
		else $error("result changed before it was taken");

endmodule
